### rtl/core/mcqd_pkg.sv
package mcqd_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int SAMPLE_BITS  = 16;

  localparam int SAMPLE_W     = 16;
  localparam int COUNT_W      = 16;
  localparam int POS_W        = 4;
  localparam int SEL_W        = 3;
  localparam int CNT_CFG_W    = 4;
  localparam int NIBBLE_SLOTS = 8;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 4;
  localparam int REG_IDX_W    = 2;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
    SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  localparam logic [REG_IDX_W-1:0] REG_A_POS     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_B_POS     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CHAN_CNT  = 2'd2;

  localparam logic [COUNT_W-1:0] STEP_UP   = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] STEP_DOWN = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] STEP_NONE = '0;

  typedef struct packed {
    logic             upd;
    logic [POS_W-1:0] a_pos;
    logic [POS_W-1:0] b_pos;
  } lane_ctl_t;

  // index is old a, old b, new a, new b
  function automatic logic [COUNT_W-1:0] step_of(input logic [3:0] idx);
    logic [COUNT_W-1:0] s;
    unique case (idx)
      4'b0010, 4'b0100, 4'b1011, 4'b1101: s = STEP_UP;
      4'b0001, 4'b0111, 4'b1000, 4'b1110: s = STEP_DOWN;
      default:                             s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

### rtl/core/mcqd_lane.sv
module mcqd_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mcqd_pkg::lane_ctl_t                  ctl_i,
  input  logic [mcqd_pkg::SAMPLE_W-1:0]        prev_sample_i,
  input  logic [mcqd_pkg::SAMPLE_W-1:0]        sample_i,
  output logic [mcqd_pkg::COUNT_W-1:0]         count_o
);

  logic [mcqd_pkg::COUNT_W-1:0] count_q, count_d;
  logic [3:0]                   idx;

  assign idx = {prev_sample_i[ctl_i.a_pos], prev_sample_i[ctl_i.b_pos],
                sample_i[ctl_i.a_pos], sample_i[ctl_i.b_pos]};

  always_comb begin
    count_d = count_q;
    if (ctl_i.upd) begin
      count_d = count_q + mcqd_pkg::step_of(idx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

### rtl/core/mcqd_merge.sv
module mcqd_merge (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  rd_i,
  input  logic [mcqd_pkg::SEL_W-1:0]                            sel_i,
  input  logic [mcqd_pkg::NUM_CHANNELS-1:0][mcqd_pkg::COUNT_W-1:0] counts_i,
  input  logic                                                  out_stall_i,
  output logic                                                  full_o,
  output logic                                                  out_valid_o,
  output logic [mcqd_pkg::COUNT_W-1:0]                          out_data_o
);

  logic [mcqd_pkg::COUNT_W-1:0] pick;
  logic                         out_valid_q, out_valid_d;
  logic [mcqd_pkg::COUNT_W-1:0] out_data_q, out_data_d;
  logic                         skid_valid_q, skid_valid_d;
  logic [mcqd_pkg::COUNT_W-1:0] skid_data_q, skid_data_d;
  logic                         take;

  // missing channels read as zero
  always_comb begin
    pick = '0;
    for (int i = 0; i < mcqd_pkg::NUM_CHANNELS; i++) begin
      if (32'(sel_i) == i) begin
        pick = counts_i[i];
      end
    end
  end

  assign take = out_valid_q & ~out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = rd_i;
        skid_data_d  = pick;
      end else begin
        out_valid_d  = rd_i;
        out_data_d   = pick;
      end
    end else if (rd_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = pick;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### rtl/core/multi_channel_quadrature_decoder.sv
// a read word's count is registered into the output register, or into the skid stage while the output is stalled
// throughput: one word per cycle while in_stall_o is low, samples and reads alike; all enabled lanes update in parallel
// input stalls only while both output register and skid stage hold unclaimed reads
// reset clears bit positions, channel count, all counters and the stored sample,
// and arms the first-sample capture
module multi_channel_quadrature_decoder (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  req_type_i,
  input  logic [mcqd_pkg::SAMPLE_W-1:0]         pin_sample_i,
  input  logic [mcqd_pkg::SEL_W-1:0]            channel_select_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [mcqd_pkg::COUNT_W-1:0]   count_value_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mcqd_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [mcqd_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [mcqd_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  logic [mcqd_pkg::APB_DATA_W-1:0] a_pos_q, b_pos_q;
  logic [mcqd_pkg::CNT_CFG_W-1:0]  chan_cnt_q;
  logic [mcqd_pkg::SAMPLE_W-1:0]   prev_q, prev_d;
  logic                            first_q, first_d;
  logic [mcqd_pkg::REG_IDX_W-1:0]  reg_idx;
  logic                            cfg_wr;
  logic                            accept, smp_acc, rd_acc;
  logic [mcqd_pkg::SAMPLE_W-1:0]   sample;
  logic [mcqd_pkg::NUM_CHANNELS-1:0][mcqd_pkg::COUNT_W-1:0] counts;
  logic [mcqd_pkg::COUNT_W-1:0]    out_data;
  logic                            full;

  assign pready  = 1'b1;
  assign reg_idx = paddr[mcqd_pkg::APB_ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_pos_q    <= '0;
      b_pos_q    <= '0;
      chan_cnt_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        mcqd_pkg::REG_A_POS:    a_pos_q    <= pwdata;
        mcqd_pkg::REG_B_POS:    b_pos_q    <= pwdata;
        mcqd_pkg::REG_CHAN_CNT: chan_cnt_q <= pwdata[mcqd_pkg::CNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mcqd_pkg::REG_A_POS:    prdata = a_pos_q;
      mcqd_pkg::REG_B_POS:    prdata = b_pos_q;
      mcqd_pkg::REG_CHAN_CNT: prdata = mcqd_pkg::APB_DATA_W'(chan_cnt_q);
      default:                prdata = '0;
    endcase
  end

  assign accept  = in_valid_i & ~in_stall_o;
  assign smp_acc = accept & ~req_type_i;
  assign rd_acc  = accept & req_type_i;
  assign sample  = pin_sample_i & mcqd_pkg::SAMPLE_MASK;

  always_comb begin
    prev_d  = prev_q;
    first_d = first_q;
    if (smp_acc) begin
      prev_d  = sample;
      first_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      first_q <= 1'b1;
    end else begin
      prev_q  <= prev_d;
      first_q <= first_d;
    end
  end

  for (genvar g = 0; g < mcqd_pkg::NUM_CHANNELS; g++) begin : g_lane
    mcqd_pkg::lane_ctl_t ctl;
    if (g < mcqd_pkg::NIBBLE_SLOTS) begin : g_cfg
      assign ctl.upd   = smp_acc & ~first_q & (32'(chan_cnt_q) > g);
      assign ctl.a_pos = a_pos_q[g*mcqd_pkg::POS_W +: mcqd_pkg::POS_W];
      assign ctl.b_pos = b_pos_q[g*mcqd_pkg::POS_W +: mcqd_pkg::POS_W];
    end else begin : g_off
      assign ctl.upd   = 1'b0;
      assign ctl.a_pos = '0;
      assign ctl.b_pos = '0;
    end

    mcqd_lane u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .prev_sample_i (prev_q),
      .sample_i      (sample),
      .count_o       (counts[g])
    );
  end

  mcqd_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_i        (rd_acc),
    .sel_i       (channel_select_i),
    .counts_i    (counts),
    .out_stall_i (out_stall_i),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data)
  );

  assign in_stall_o    = full;
  assign count_value_o = $signed(out_data);

endmodule

### rtl/core/mcqd_checker.sv
module mcqd_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic                                  req_type_i,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic signed [mcqd_pkg::COUNT_W-1:0]   count_value_o,
  input logic                                  pready
);

  // input backs up only behind unclaimed reads
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // a sample word never produces a result
  a_no_spurious_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !(in_valid_i && !in_stall_o && req_type_i)) |=> !out_valid_o)
    else $error("result without a read word");

  // an accepted read with a free output shows up next cycle
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && in_valid_i && !in_stall_o && req_type_i) |=> out_valid_o)
    else $error("read word lost");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(count_value_o)))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind multi_channel_quadrature_decoder mcqd_checker u_mcqd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .req_type_i    (req_type_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .count_value_o (count_value_o),
  .pready        (pready)
);
